>>> hw/rtl/ppt_pkg.sv
// ---------------------------------------------------------------------------
// ppt_pkg: shared definitions for the pointer position tracker
// Field widths, clamp limits, register indexes and the default precision.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppt_pkg;

   // default number of fraction bits in the position accumulators
   localparam int DEFAULT_FRACTION_BITS = 16;

   // payload widths
   localparam int DELTA_W   = 16;
   localparam int BUTTON_W  = 8;
   localparam int WHEEL_W   = 8;
   localparam int WSUM_W    = 16;
   localparam int POS_X_W   = 9;
   localparam int POS_Y_W   = 8;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam int DIV_W       = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_SENSITIVITY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WIDE_TIMING = 2'd1;

   // request kinds
   localparam logic MODE_REPORT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   // response status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NO_PTR  = 1'b1;

   // screen limits, absolute offset and divisor range
   localparam logic [POS_X_W-1:0] X_LIMIT    = 9'd319;
   localparam logic [POS_Y_W-1:0] Y_LIMIT    = 8'd199;
   localparam logic [6:0]         ABS_OFFSET = 7'd32;
   localparam logic [DIV_W-1:0]   DIV_MIN    = 4'd1;
   localparam logic [DIV_W-1:0]   DIV_MAX    = 4'd8;
   localparam logic [DIV_W-1:0]   DIV_RESET  = 4'd4;

   // wheel readout limits
   localparam logic signed [WSUM_W-1:0] WHEEL_OUT_MAX = 16'sd127;
   localparam logic signed [WSUM_W-1:0] WHEEL_OUT_MIN = -16'sd128;

endpackage

>>> hw/rtl/pointer_position_tracker.sv
// ---------------------------------------------------------------------------
// pointer_position_tracker: pointer position accumulator and query port
// Tracks a fixed-point pointer position from relative or absolute reports
// and answers position queries with position, buttons and wheel motion.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// One request beat is taken per clock unless stalled. Reports update the
// position, button and wheel state in the cycle they are accepted and return
// nothing, but absolute ones with a negative coordinate are dropped. A query
// returns one response beat in the next cycle. Reports are never stalled; a
// query is stalled only while the response register holds an untaken beat
// that is itself stalled. The per-beat work is one 16 x (FRACTION_BITS+1)
// multiply by a constant reciprocal of the sensitivity divisor plus a
// clamped add, all between the request port and the state and response
// registers. Sensitivity writes of 0 act as 1 and writes above 8 act as 8.
module pointer_position_tracker #(
   parameter int FRACTION_BITS = ppt_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_mode,
   input  logic signed [ppt_pkg::DELTA_W-1:0]      req_delta_x,
   input  logic signed [ppt_pkg::DELTA_W-1:0]      req_delta_y,
   input  logic        [ppt_pkg::BUTTON_W-1:0]     req_button_mask,
   input  logic signed [ppt_pkg::WHEEL_W-1:0]      req_wheel_delta,
   input  logic                                    req_absolute,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_status,
   output logic        [ppt_pkg::POS_X_W-1:0]      rsp_pos_x,
   output logic        [ppt_pkg::POS_Y_W-1:0]      rsp_pos_y,
   output logic        [ppt_pkg::BUTTON_W-1:0]     rsp_buttons,
   output logic signed [ppt_pkg::WHEEL_W-1:0]      rsp_wheel,
   // configuration write channel
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [ppt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic        [ppt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ppt_pkg::*;

   // position widths and derived constants
   localparam int XW  = FRACTION_BITS + POS_X_W;       // x accumulator
   localparam int YW  = FRACTION_BITS + POS_Y_W;       // y accumulator
   localparam int RW  = FRACTION_BITS + 1;             // reciprocal
   localparam int PW  = DELTA_W + RW + 1;              // signed product
   localparam int SW  = PW + 1;                        // signed sum
   localparam int ONE = 1 << FRACTION_BITS;

   localparam logic [XW-1:0] X_MAX = {X_LIMIT, {FRACTION_BITS{1'b0}}};
   localparam logic [YW-1:0] Y_MAX = {Y_LIMIT, {FRACTION_BITS{1'b0}}};

   // round-half-up reciprocals of divisors 1..8, indexed by divisor - 1
   localparam logic [RW-1:0] RECIP_TABLE [8] = '{
      RW'(ONE),
      RW'((ONE + 1) / 2),
      RW'((ONE + 1) / 3),
      RW'((ONE + 2) / 4),
      RW'((ONE + 2) / 5),
      RW'((ONE + 3) / 6),
      RW'((ONE + 3) / 7),
      RW'((ONE + 4) / 8)
   };

   // configuration registers
   logic [DIV_W-1:0] sens_ff;
   logic             wide_ff;

   // tracker state
   logic        [XW-1:0]       x_pos_ff, x_pos_in;
   logic        [YW-1:0]       y_pos_ff, y_pos_in;
   logic        [BUTTON_W-1:0] buttons_ff, buttons_in;
   logic signed [WSUM_W-1:0]   wheel_sum_ff, wheel_sum_in;
   logic                       seen_ff, seen_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_status_ff, rsp_status_in;
   logic        [POS_X_W-1:0]  rsp_pos_x_ff, rsp_pos_x_in;
   logic        [POS_Y_W-1:0]  rsp_pos_y_ff, rsp_pos_y_in;
   logic        [BUTTON_W-1:0] rsp_buttons_ff, rsp_buttons_in;
   logic signed [WHEEL_W-1:0]  rsp_wheel_ff, rsp_wheel_in;

   // datapath
   logic                       req_fire;
   logic                       is_report;
   logic                       is_query;
   logic                       abs_drop;
   logic        [DIV_W-1:0]    div_clamped;
   logic        [2:0]          recip_idx;
   logic signed [PW-1:0]       recip_ext;
   logic signed [PW-1:0]       dx_ext, dy_ext;
   logic signed [PW-1:0]       prod_x, prod_y;
   logic signed [SW-1:0]       sum_x, sum_y;
   logic        [XW-1:0]       x_rel;
   logic        [YW-1:0]       y_rel;
   logic signed [DELTA_W:0]    ax, ay;
   logic        [DELTA_W-2:0]  hx, hy;
   logic        [POS_X_W-1:0]  cx;
   logic        [POS_Y_W-1:0]  cy;
   logic signed [WSUM_W:0]     wheel_acc;
   logic signed [WSUM_W-1:0]   wheel_sat;
   logic signed [WHEEL_W-1:0]  wheel_out;

   // handshakes: only a query can be held up by a blocked response
   assign req_stall = rsp_valid_ff & rsp_stall & (req_mode == MODE_QUERY);
   assign req_fire  = req_valid & ~req_stall;
   assign is_report = req_fire & (req_mode == MODE_REPORT);
   assign is_query  = req_fire & (req_mode == MODE_QUERY);
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff <= DIV_RESET;
         wide_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_SENSITIVITY) begin
            sens_ff <= csr_wdata[DIV_W-1:0];
         end
         if (csr_index == REG_WIDE_TIMING) begin
            wide_ff <= csr_wdata[0];
         end
      end
   end

   // divisor clamp and reciprocal lookup
   always_comb begin
      priority if (sens_ff < DIV_MIN) begin
         div_clamped = DIV_MIN;
      end else if (sens_ff > DIV_MAX) begin
         div_clamped = DIV_MAX;
      end else begin
         div_clamped = sens_ff;
      end
      recip_idx = 3'(div_clamped - DIV_MIN);
      recip_ext = PW'(RECIP_TABLE[recip_idx]);
   end

   // relative step: scaled delta added to the position, then clamped
   always_comb begin
      dx_ext = {{(PW-DELTA_W){req_delta_x[DELTA_W-1]}}, req_delta_x};
      dy_ext = {{(PW-DELTA_W){req_delta_y[DELTA_W-1]}}, req_delta_y};
      prod_x = dx_ext * recip_ext;
      prod_y = dy_ext * recip_ext;
      sum_x  = signed'({{(SW-XW){1'b0}}, x_pos_ff}) + {prod_x[PW-1], prod_x};
      sum_y  = signed'({{(SW-YW){1'b0}}, y_pos_ff}) + {prod_y[PW-1], prod_y};
      priority if (sum_x < 0) begin
         x_rel = '0;
      end else if (sum_x > signed'({{(SW-XW){1'b0}}, X_MAX})) begin
         x_rel = X_MAX;
      end else begin
         x_rel = sum_x[XW-1:0];
      end
      priority if (sum_y < 0) begin
         y_rel = '0;
      end else if (sum_y > signed'({{(SW-YW){1'b0}}, Y_MAX})) begin
         y_rel = Y_MAX;
      end else begin
         y_rel = sum_y[YW-1:0];
      end
   end

   // absolute step: offset (not x if wide), halve toward zero, screen clamp
   always_comb begin
      ax = {req_delta_x[DELTA_W-1], req_delta_x}
         - (wide_ff ? '0 : signed'((DELTA_W+1)'(ABS_OFFSET)));
      ay = {req_delta_y[DELTA_W-1], req_delta_y}
         - signed'((DELTA_W+1)'(ABS_OFFSET));
      // negative values halve to zero or below and clamp to zero
      hx = ax[DELTA_W] ? '0 : ax[DELTA_W-1:1];
      hy = ay[DELTA_W] ? '0 : ay[DELTA_W-1:1];
      cx = (hx > (DELTA_W-1)'(X_LIMIT)) ? X_LIMIT : hx[POS_X_W-1:0];
      cy = (hy > (DELTA_W-1)'(Y_LIMIT)) ? Y_LIMIT : hy[POS_Y_W-1:0];
      abs_drop = req_absolute & (req_delta_x[DELTA_W-1] | req_delta_y[DELTA_W-1]);
   end

   // wheel accumulate with 16-bit saturation, and 8-bit readout clamp
   always_comb begin
      wheel_acc = {wheel_sum_ff[WSUM_W-1], wheel_sum_ff}
                + {{(WSUM_W+1-WHEEL_W){req_wheel_delta[WHEEL_W-1]}}, req_wheel_delta};
      priority if (wheel_acc[WSUM_W] != wheel_acc[WSUM_W-1]) begin
         wheel_sat = wheel_acc[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}}
                                       : {1'b0, {(WSUM_W-1){1'b1}}};
      end else begin
         wheel_sat = wheel_acc[WSUM_W-1:0];
      end
      priority if (wheel_sum_ff > WHEEL_OUT_MAX) begin
         wheel_out = WHEEL_OUT_MAX[WHEEL_W-1:0];
      end else if (wheel_sum_ff < WHEEL_OUT_MIN) begin
         wheel_out = WHEEL_OUT_MIN[WHEEL_W-1:0];
      end else begin
         wheel_out = wheel_sum_ff[WHEEL_W-1:0];
      end
   end

   // next state and response
   always_comb begin
      x_pos_in       = x_pos_ff;
      y_pos_in       = y_pos_ff;
      buttons_in     = buttons_ff;
      wheel_sum_in   = wheel_sum_ff;
      seen_in        = seen_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_pos_x_in   = rsp_pos_x_ff;
      rsp_pos_y_in   = rsp_pos_y_ff;
      rsp_buttons_in = rsp_buttons_ff;
      rsp_wheel_in   = rsp_wheel_ff;

      if (is_report && !abs_drop) begin
         if (req_absolute) begin
            x_pos_in = {cx, {FRACTION_BITS{1'b0}}};
            y_pos_in = {cy, {FRACTION_BITS{1'b0}}};
         end else begin
            x_pos_in = x_rel;
            y_pos_in = y_rel;
         end
         buttons_in   = req_button_mask;
         wheel_sum_in = wheel_sat;
         seen_in      = 1'b1;
      end

      if (is_query) begin
         rsp_valid_in = 1'b1;
         if (seen_ff) begin
            rsp_status_in  = STATUS_OK;
            rsp_pos_x_in   = x_pos_ff[XW-1:FRACTION_BITS];
            rsp_pos_y_in   = y_pos_ff[YW-1:FRACTION_BITS];
            rsp_buttons_in = buttons_ff;
            rsp_wheel_in   = wheel_out;
            wheel_sum_in   = '0;
         end else begin
            rsp_status_in  = STATUS_NO_PTR;
            rsp_pos_x_in   = '0;
            rsp_pos_y_in   = '0;
            rsp_buttons_in = '0;
            rsp_wheel_in   = '0;
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_pos_ff     <= '0;
         y_pos_ff     <= '0;
         buttons_ff   <= '0;
         wheel_sum_ff <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x_pos_ff     <= x_pos_in;
         y_pos_ff     <= y_pos_in;
         buttons_ff   <= buttons_in;
         wheel_sum_ff <= wheel_sum_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_pos_x_ff   <= rsp_pos_x_in;
      rsp_pos_y_ff   <= rsp_pos_y_in;
      rsp_buttons_ff <= rsp_buttons_in;
      rsp_wheel_ff   <= rsp_wheel_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_pos_x   = rsp_pos_x_ff;
   assign rsp_pos_y   = rsp_pos_y_ff;
   assign rsp_buttons = rsp_buttons_ff;
   assign rsp_wheel   = rsp_wheel_ff;

   // checks
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (x_pos_ff <= X_MAX) && (y_pos_ff <= Y_MAX))
      else $error("position accumulator outside the screen");

   a_wheel_cleared: assert property (@(posedge clock) disable iff (reset)
      (is_query && seen_ff) |=> (wheel_sum_ff == '0))
      else $error("wheel sum not cleared after a query");

   // a report may land while the no-pointer beat still waits, so only the
   // payload is checked here
   a_no_ptr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_NO_PTR) |->
         (rsp_pos_x_ff == '0 && rsp_pos_y_ff == '0 && rsp_buttons_ff == '0
          && rsp_wheel_ff == '0))
      else $error("no-pointer response carries data");

   a_stall_needs_beat: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("request stalled with an empty response register");

endmodule
